// ===== design/bba_pkg.sv =====
// shared constants and types of the bitmap buddy allocator
`default_nettype none

package bba_pkg;

	localparam int MIN_BLOCK_BYTES_DEF = 1024;
	localparam int MAX_BLOCKS_DEF      = 4096;
	localparam int MAX_LEVELS_DEF      = 13;

	localparam int WORD_W    = 32;
	localparam int WORD_LOG  = 5;
	localparam int ADDR_W    = 48;
	localparam int BYTES_W   = 32;
	localparam int COUNT_W   = 13;
	localparam int STATUS_W  = 3;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 64;

	localparam logic [COUNT_W-1:0] RESET_COUNT = 13'd4096;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_OVER_CAP  = 3'd2,
		ST_NO_FREE   = 3'd3,
		ST_NULL      = 3'd4,
		ST_NOT_ALLOC = 3'd5
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_COUNT = 1'b0,
		REG_START = 1'b1
	} reg_index_t;

endpackage

`default_nettype wire

// ===== design/bitmap_buddy_allocator.sv =====
// Buddy allocator over a power-of-two block hierarchy: one request in, one
// result out. The free bitmaps sit in one ram of 32-bit words (one row of
// words per level) and the level records in a second ram; each bitmap
// update is a read, then a write back in the next cycle, so one request runs
// at a time. MIN_BLOCK_BYTES must be a power of two. After reset and after
// every register write a clearing pass rebuilds both rams while no request
// is taken. An allocate skips levels with a zero free count, scans bitmap
// words and splits levels down to the request level. A free merges levels
// with free buddies; the minimum block index is found by a shift. A
// finished result waits in the output register while the next request is
// taken.
`default_nettype none

module bitmap_buddy_allocator import bba_pkg::*; #(
	parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
	parameter int MAX_BLOCKS      = MAX_BLOCKS_DEF,
	parameter int MAX_LEVELS      = MAX_LEVELS_DEF,
	localparam int USED_W = $clog2(longint'(MAX_BLOCKS) * longint'(MIN_BLOCK_BYTES) + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic      [PDATA_W-1:0]  prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                cmd,
	input  wire logic [BYTES_W-1:0]  request_bytes,
	input  wire logic [ADDR_W-1:0]   free_address,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [STATUS_W-1:0] status,
	output logic      [ADDR_W-1:0]   granted_address,
	output logic      [USED_W-1:0]   used_bytes
);

	localparam int IDX_W    = $clog2(MAX_BLOCKS);
	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int LV_W     = $clog2(MAX_LEVELS + 1);
	localparam int LI_W     = $clog2(MAX_LEVELS);
	localparam int WPL      = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WB       = (WPL > 1) ? $clog2(WPL) : 1;
	localparam int BM_DEPTH = MAX_LEVELS * (2 ** WB);
	localparam int BA_W     = $clog2(BM_DEPTH);
	localparam int MIN_W    = $clog2(MIN_BLOCK_BYTES + 1);
	localparam int AL_W     = MIN_W + MAX_LEVELS - 1;
	localparam int CMP_W    = (AL_W > BYTES_W) ? AL_W : BYTES_W;
	localparam int SUM_W    = CMP_W + 1;
	localparam int P_W      = MIN_W + IDX_W;
	localparam int SWEEP_LEN = (BM_DEPTH > MAX_BLOCKS) ? BM_DEPTH : MAX_BLOCKS;
	localparam int SW_W     = $clog2(SWEEP_LEN + 1);
	localparam logic [LV_W-1:0] REC_NONE = {LV_W{1'b1}};

	typedef enum logic [19:0] {
		S_PREP     = 20'h00001,
		S_SWEEP    = 20'h00002,
		S_IDLE     = 20'h00004,
		S_ALLOC    = 20'h00008,
		S_CAP      = 20'h00010,
		S_SCAN     = 20'h00020,
		S_SCAN_CHK = 20'h00040,
		S_SPLIT_RD = 20'h00080,
		S_SPLIT_WR = 20'h00100,
		S_GRANT    = 20'h00200,
		S_GRANT2   = 20'h00400,
		S_FREE     = 20'h00800,
		S_RANGE    = 20'h01000,
		S_DIV      = 20'h02000,
		S_REC_RD   = 20'h04000,
		S_REC_CHK  = 20'h08000,
		S_MERGE_RD = 20'h10000,
		S_MERGE_WR = 20'h20000,
		S_FREE_END = 20'h40000,
		S_DONE     = 20'h80000
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   cfg_count_q;
	logic [ADDR_W-1:0]    start_q;
	logic [CNT_W-1:0]     eff_count_q;
	logic [LV_W-1:0]      eff_levels_q;
	logic [USED_W-1:0]    cap_q;
	logic [SW_W-1:0]      sweep_q;
	logic [CNT_W-1:0]     free_cnt_q [MAX_LEVELS];
	logic [USED_W-1:0]    used_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [ADDR_W-1:0]    faddr_q;
	logic [LV_W-1:0]      lvl_q;
	logic [LV_W-1:0]      cur_q;
	logic [IDX_W-1:0]     off_q;
	logic [WB-1:0]        word_q;
	logic [CMP_W-1:0]     aligned_q;
	logic [ADDR_W-1:0]    rel_q;
	logic [IDX_W-1:0]     idx_q;
	logic [P_W-1:0]       prod_q;
	status_t              res_status_q;
	logic [ADDR_W-1:0]    res_granted_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ADDR_W-1:0]    out_granted_q;
	logic [USED_W-1:0]    out_used_q;

	logic                 cfg_wr;
	logic [CNT_W-1:0]     eff_count_d;
	logic [LV_W-1:0]      eff_levels_d;
	logic                 fit_hit;
	logic [LV_W-1:0]      fit_lvl;
	logic [CMP_W-1:0]     fit_aligned;
	logic [LI_W-1:0]      cur_i;
	logic [CNT_W-1:0]     cur_cnt;
	logic [CNT_W-1:0]     lvl_blocks;
	logic [WORD_LOG-1:0]  bit_p;
	logic [WORD_LOG-1:0]  bit_b;
	logic [BA_W-1:0]      addr_scan;
	logic [BA_W-1:0]      addr_off;
	logic [SW_W-1:0]      sw_lvl;
	logic [WB-1:0]        sw_word;
	logic [CNT_W-1:0]     sw_n;
	logic [CNT_W-1:0]     sw_tail;
	logic [IDX_W-1:0]     grant_idx;
	logic                 buddy_free;
	logic                 out_load;

	logic                 bm_we;
	logic [BA_W-1:0]      bm_addr;
	logic [WORD_W-1:0]    bm_wdata;
	logic [WORD_W-1:0]    bm_rdata;
	logic                 rec_we;
	logic [IDX_W-1:0]     rec_addr;
	logic [LV_W-1:0]      rec_wdata;
	logic [LV_W-1:0]      rec_rdata;

	logic                 div_start;
	logic                 div_done;
	logic [IDX_W-1:0]     div_q;

	function automatic logic [WORD_LOG-1:0] low_bit(input logic [WORD_W-1:0] w);
		logic [WORD_LOG-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = WORD_LOG'(i);
			end
		end
		return r;
	endfunction

	bba_ram #(.WIDTH(WORD_W), .DEPTH(BM_DEPTH)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.addr  (bm_addr),
		.wdata (bm_wdata),
		.rdata (bm_rdata)
	);

	bba_ram #(.WIDTH(LV_W), .DEPTH(MAX_BLOCKS)) u_record (
		.clk   (clk),
		.we    (rec_we),
		.addr  (rec_addr),
		.wdata (rec_wdata),
		.rdata (rec_rdata)
	);

	bba_cdiv #(.DIVISOR(MIN_BLOCK_BYTES), .DVD_W(USED_W), .Q_W(IDX_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rel_q[USED_W-1:0]),
		.done     (div_done),
		.quotient (div_q)
	);

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_START) ? PDATA_W'(start_q) : PDATA_W'(cfg_count_q);

	// effective block count and level count from the count register
	always_comb begin
		eff_count_d = (cfg_count_q > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cfg_count_q);
		eff_levels_d = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (eff_count_d[i]) begin
				eff_levels_d = (i + 1 > MAX_LEVELS) ? LV_W'(MAX_LEVELS) : LV_W'(i + 1);
			end
		end
	end

	// smallest level whose block holds the request
	always_comb begin
		fit_hit     = 1'b0;
		fit_lvl     = '0;
		fit_aligned = '0;
		for (int l = 0; l < MAX_LEVELS; l++) begin
			if (!fit_hit && (LV_W'(l) < eff_levels_q) &&
			    (CMP_W'(bytes_q) <= (CMP_W'(MIN_BLOCK_BYTES) << l))) begin
				fit_hit     = 1'b1;
				fit_lvl     = LV_W'(l);
				fit_aligned = CMP_W'(MIN_BLOCK_BYTES) << l;
			end
		end
	end

	always_comb begin
		cur_i      = cur_q[LI_W-1:0];
		cur_cnt    = free_cnt_q[cur_i];
		lvl_blocks = eff_count_q >> cur_q;
		bit_p      = WORD_LOG'(off_q);
		bit_b      = bit_p ^ WORD_LOG'(1);
		addr_scan  = BA_W'({cur_i, word_q});
		addr_off   = BA_W'({cur_i, WB'(off_q >> WORD_LOG)});
		sw_lvl     = sweep_q >> WB;
		sw_word    = sweep_q[WB-1:0];
		sw_n       = eff_count_q >> sw_lvl;
		sw_tail    = sw_n - CNT_W'(1);
		grant_idx  = off_q << lvl_q;
		buddy_free = ((off_q ^ IDX_W'(1)) < lvl_blocks) && bm_rdata[bit_b];
		out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	// ram port control
	always_comb begin
		bm_we     = 1'b0;
		bm_addr   = addr_off;
		bm_wdata  = bm_rdata;
		rec_we    = 1'b0;
		rec_addr  = idx_q;
		rec_wdata = REC_NONE;
		case (state_q)
			S_SWEEP: begin
				bm_addr  = sweep_q[BA_W-1:0];
				bm_we    = (sweep_q < SW_W'(BM_DEPTH));
				bm_wdata = '0;
				if ((sw_lvl < eff_levels_q) && sw_n[0] &&
				    (WB'(sw_tail >> WORD_LOG) == sw_word)) begin
					bm_wdata = WORD_W'(1) << WORD_LOG'(sw_tail);
				end
				rec_addr = sweep_q[IDX_W-1:0];
				rec_we   = (sweep_q < SW_W'(MAX_BLOCKS));
			end
			S_SCAN: begin
				bm_addr = addr_scan;
			end
			S_SCAN_CHK: begin
				bm_addr  = addr_scan;
				bm_we    = (bm_rdata != '0);
				bm_wdata = bm_rdata & ~(WORD_W'(1) << low_bit(bm_rdata));
			end
			S_SPLIT_WR: begin
				bm_we    = 1'b1;
				bm_wdata = (bm_rdata & ~(WORD_W'(1) << bit_p)) | (WORD_W'(1) << bit_b);
			end
			S_MERGE_WR: begin
				bm_we = 1'b1;
				if (buddy_free) begin
					bm_wdata = bm_rdata & ~(WORD_W'(1) << bit_p) & ~(WORD_W'(1) << bit_b);
				end else begin
					bm_wdata = bm_rdata | (WORD_W'(1) << bit_p);
				end
			end
			S_GRANT: begin
				rec_addr  = grant_idx;
				rec_we    = 1'b1;
				rec_wdata = lvl_q;
			end
			S_REC_CHK: begin
				rec_we = !((rec_rdata == REC_NONE) || (rec_rdata >= eff_levels_q));
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == S_RANGE) && (rel_q < ADDR_W'(cap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_PREP;
			cfg_count_q   <= RESET_COUNT;
			start_q       <= '0;
			eff_count_q   <= '0;
			eff_levels_q  <= '0;
			cap_q         <= '0;
			sweep_q       <= '0;
			for (int l = 0; l < MAX_LEVELS; l++) begin
				free_cnt_q[l] <= '0;
			end
			used_q        <= '0;
			bytes_q       <= '0;
			faddr_q       <= '0;
			lvl_q         <= '0;
			cur_q         <= '0;
			off_q         <= '0;
			word_q        <= '0;
			aligned_q     <= '0;
			rel_q         <= '0;
			idx_q         <= '0;
			prod_q        <= '0;
			res_status_q  <= ST_OK;
			res_granted_q <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_granted_q <= '0;
			out_used_q    <= '0;
		end else begin
			eff_count_q  <= eff_count_d;
			eff_levels_q <= eff_levels_d;
			cap_q        <= USED_W'(eff_count_q) * USED_W'(MIN_BLOCK_BYTES);

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_status_q  <= res_status_q;
				out_granted_q <= res_granted_q;
				out_used_q    <= used_q;
			end

			case (state_q)
				S_PREP: begin
					sweep_q <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (sweep_q == '0) begin
						used_q <= '0;
						for (int l = 0; l < MAX_LEVELS; l++) begin
							free_cnt_q[l] <= CNT_W'((LV_W'(l) < eff_levels_q) &&
							                        (((eff_count_q >> l) & CNT_W'(1)) != '0));
						end
					end
					sweep_q <= sweep_q + SW_W'(1);
					if (sweep_q == SW_W'(SWEEP_LEN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						bytes_q       <= request_bytes;
						faddr_q       <= free_address;
						res_granted_q <= '0;
						state_q       <= (cmd == CMD_FREE) ? S_FREE : S_ALLOC;
					end
				end
				S_ALLOC: begin
					lvl_q     <= fit_lvl;
					cur_q     <= fit_lvl;
					aligned_q <= fit_aligned;
					word_q    <= '0;
					if (!fit_hit) begin
						res_status_q <= ST_TOO_LARGE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_CAP;
					end
				end
				S_CAP: begin
					if (SUM_W'(used_q) + SUM_W'(aligned_q) > SUM_W'(cap_q)) begin
						res_status_q <= ST_OVER_CAP;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cur_q >= eff_levels_q) begin
						res_status_q <= ST_NO_FREE;
						state_q      <= S_DONE;
					end else if (cur_cnt == '0) begin
						cur_q  <= cur_q + LV_W'(1);
						word_q <= '0;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					// a nonzero count means a set bit lies in a later word
					if (bm_rdata == '0) begin
						word_q  <= word_q + WB'(1);
						state_q <= S_SCAN;
					end else begin
						free_cnt_q[cur_i] <= cur_cnt - CNT_W'(1);
						if (cur_q == lvl_q) begin
							off_q   <= IDX_W'({word_q, low_bit(bm_rdata)});
							state_q <= S_GRANT;
						end else begin
							off_q   <= IDX_W'({word_q, low_bit(bm_rdata)}) << 1;
							cur_q   <= cur_q - LV_W'(1);
							state_q <= S_SPLIT_RD;
						end
					end
				end
				S_SPLIT_RD: begin
					state_q <= S_SPLIT_WR;
				end
				S_SPLIT_WR: begin
					free_cnt_q[cur_i] <= cur_cnt - CNT_W'(bm_rdata[bit_p]) +
					                     CNT_W'(!bm_rdata[bit_b]);
					if (cur_q == lvl_q) begin
						state_q <= S_GRANT;
					end else begin
						cur_q   <= cur_q - LV_W'(1);
						off_q   <= off_q << 1;
						state_q <= S_SPLIT_RD;
					end
				end
				S_GRANT: begin
					prod_q  <= P_W'(grant_idx) * P_W'(MIN_BLOCK_BYTES);
					used_q  <= used_q + USED_W'(aligned_q);
					state_q <= S_GRANT2;
				end
				S_GRANT2: begin
					res_granted_q <= start_q + ADDR_W'(prod_q);
					res_status_q  <= ST_OK;
					state_q       <= S_DONE;
				end
				S_FREE: begin
					rel_q <= faddr_q - start_q;
					if (faddr_q == '0) begin
						res_status_q <= ST_NULL;
						state_q      <= S_DONE;
					end else if (faddr_q < start_q) begin
						res_status_q <= ST_NOT_ALLOC;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						res_status_q <= ST_NOT_ALLOC;
						state_q      <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q   <= div_q;
						state_q <= S_REC_RD;
					end
				end
				S_REC_RD: begin
					state_q <= S_REC_CHK;
				end
				S_REC_CHK: begin
					if ((rec_rdata == REC_NONE) || (rec_rdata >= eff_levels_q)) begin
						res_status_q <= ST_NOT_ALLOC;
						state_q      <= S_DONE;
					end else begin
						lvl_q     <= rec_rdata;
						cur_q     <= rec_rdata;
						off_q     <= idx_q >> rec_rdata;
						aligned_q <= CMP_W'(MIN_BLOCK_BYTES) << rec_rdata;
						state_q   <= S_MERGE_RD;
					end
				end
				S_MERGE_RD: begin
					state_q <= (cur_q >= eff_levels_q) ? S_FREE_END : S_MERGE_WR;
				end
				S_MERGE_WR: begin
					if (buddy_free) begin
						// pair merges: both halves leave this level
						free_cnt_q[cur_i] <= cur_cnt -
						                     (bm_rdata[bit_p] ? CNT_W'(2) : CNT_W'(1));
						off_q   <= off_q >> 1;
						cur_q   <= cur_q + LV_W'(1);
						state_q <= S_MERGE_RD;
					end else begin
						free_cnt_q[cur_i] <= cur_cnt + CNT_W'(!bm_rdata[bit_p]);
						state_q           <= S_FREE_END;
					end
				end
				S_FREE_END: begin
					used_q       <= (used_q >= aligned_q) ? used_q - USED_W'(aligned_q) : '0;
					res_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_PREP;
				end
			endcase

			if (cfg_wr) begin
				if (paddr[3] == REG_START) begin
					start_q <= pwdata[ADDR_W-1:0];
				end else begin
					cfg_count_q <= pwdata[COUNT_W-1:0];
				end
				state_q <= S_PREP;
			end
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign granted_address = out_granted_q;
	assign used_bytes      = out_used_q;

	a_grant_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRANT) |-> (cur_q == lvl_q))
		else $error("grant reached above the request level");

	a_split_even: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT_WR) |-> (off_q[0] == 1'b0))
		else $error("split offset is not the lower half");

	a_merge_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE_WR) |-> (cur_q < eff_levels_q))
		else $error("merge beyond the top level");

	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_PREP) && (state_q != S_SWEEP)) |-> (used_q <= cap_q))
		else $error("used bytes exceed capacity");

endmodule

`default_nettype wire

// ===== design/bba_ram.sv =====
// generic single-port synchronous ram with registered read
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== design/bba_cdiv.sv =====
// divider by a constant power of two, quotient registered in the cycle after start
`default_nettype none

module bba_cdiv #(
	parameter int DIVISOR = 1024,
	parameter int DVD_W   = 23,
	parameter int Q_W     = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	output logic                  done,
	output logic      [Q_W-1:0]   quotient
);

	localparam int SH = $clog2(DIVISOR);

	logic           done_q;
	logic [Q_W-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quo_q  <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				quo_q <= Q_W'(dividend >> SH);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire
